FILE: rtl/edts_pkg.sv
// ============================================================================
// edts_pkg: shared types and constants of the torque split
// Field widths, register indexes, mode codes, the lane control struct and the
// per-degree tangent table that is built once during elaboration.
// ============================================================================
package edts_pkg;

    localparam int TAN_FRAC_BITS = 16;
    localparam int TORQUE_BITS   = 12;

    localparam int ANG_W   = 8;
    localparam int ACC_W   = 16;
    localparam int RATIO_W = 16;
    localparam int GAIN_W  = 16;
    localparam int DB_W    = 6;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam int ANGLE_MAX = 89;
    localparam int MAG_W     = 7;

    // The tangent stays below 64 over the table, so six integer bits suffice.
    localparam int TAN_W  = TAN_FRAC_BITS + 6;
    localparam int P_W    = RATIO_W + TAN_W;
    localparam int KA_W   = GAIN_W + ACC_W;
    localparam int F1_W   = P_W + 3;
    localparam int F1M_W  = F1_W - 1;
    localparam int F2_W   = KA_W + 2;
    localparam int F2M_W  = F2_W - 1;
    localparam int F2L_W  = (F2M_W + 1) / 2;
    localparam int F2H_W  = F2M_W - F2L_W;
    localparam int A_W    = TORQUE_BITS + F1M_W;
    localparam int LO_W   = A_W + F2L_W;
    localparam int HI_W   = A_W + F2H_W;
    localparam int PROD_W = A_W + F2M_W;
    localparam int ONE_SHIFT  = 15 + TAN_FRAC_BITS;
    localparam int UNIT_SHIFT = 20;
    localparam int OUT_SHIFT  = ONE_SHIFT + UNIT_SHIFT;

    localparam int IN_W  = TORQUE_BITS + ANG_W + ACC_W;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 2 * TORQUE_BITS;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [IDX_W-1:0] REG_TRACK_RATIO = 2'd1;
    localparam logic [IDX_W-1:0] REG_ACCEL_GAIN  = 2'd2;
    localparam logic [IDX_W-1:0] REG_DEAD_BAND   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_PASS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INNER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HALF  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DEAD  = 2'd3;

    localparam logic [MODE_W-1:0]  MODE_RESET      = MODE_PASS;
    localparam logic [RATIO_W-1:0] RATIO_RESET     = 16'd16384;
    localparam logic [GAIN_W-1:0]  GAIN_RESET      = 16'd0;
    localparam logic [DB_W-1:0]    DEAD_BAND_RESET = 6'd3;

    // Per wheel: pass the request through, use the minus branch of both
    // factors, double the ratio term, apply the acceleration term.
    typedef struct packed {
        logic pass;
        logic minus;
        logic dbl;
        logic use_ka;
    } lane_ctl_t;

    typedef lane_ctl_t [1:0] lane_ctl_pair_t;

    typedef logic [ANGLE_MAX:0][TAN_W-1:0] tan_rom_t;

    // Restoring division, used only while the table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Tangent in Q(TAN_FRAC_BITS) from truncating Q30 sine and cosine series.
    function automatic logic [TAN_W-1:0] rom_tan(input int unsigned a);
        logic [63:0]        th;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        c;
        logic signed [63:0] sn;
        logic signed [63:0] cs;
        logic [63:0]        q;
        th = (64'(a) * 64'd31415) << 30;
        th = (th + 64'd900000) / 64'd1800000;
        x2 = (th * th) >> 30;
        term = th;
        sn = $signed(th);
        for (int n = 1; n <= 11; n++) begin
            term = udiv64((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
            sn = (n % 2 == 1) ? sn - $signed(term) : sn + $signed(term);
        end
        term = 64'd1 << 30;
        cs = $signed(64'd1 << 30);
        for (int n = 1; n <= 11; n++) begin
            term = udiv64((term * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
            cs = (n % 2 == 1) ? cs - $signed(term) : cs + $signed(term);
        end
        if (sn < 0) begin
            sn = '0;
        end
        if (cs <= 0) begin
            q = '0;
        end else begin
            c = $unsigned(cs);
            q = udiv64(($unsigned(sn) << TAN_FRAC_BITS) + (c >> 1), c);
        end
        return q[TAN_W-1:0];
    endfunction

    function automatic tan_rom_t build_tan_rom();
        tan_rom_t rom;
        for (int a = 0; a <= ANGLE_MAX; a++) begin
            rom[a] = rom_tan(a);
        end
        return rom;
    endfunction

    localparam tan_rom_t TAN_ROM = build_tan_rom();

endpackage

FILE: rtl/electronic_differential_torque_split.sv
// ============================================================================
// electronic_differential_torque_split: right and left wheel torque commands
// Splits a torque request by steering angle and lateral acceleration in an
// eight-stage pipeline with at most two multipliers in any stage.
// ============================================================================
//
//  Channel   Direction  Handshake               Payload
//  s_axis    in         tvalid/tready           torque_request, steer_angle, lateral_accel
//  m_axis    out        tvalid/tready           right_torque, left_torque
//  cfg       in         cfg_we (no wait)        cfg_index, cfg_data
//
// One transaction enters per cycle while the output is not stalled; each result
// passes through the chain of tangent lookup, ratio and gain products and the
// split 52 x 33 bit final product.
// Reset clears the stage valid bits and loads the register reset values.
// A stall at the output backs up stage by stage; empty stages still fill.

module electronic_differential_torque_split
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [edts_pkg::IDX_W-1:0]    cfg_index,
    input  logic [edts_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // torque_request[11:0], steer_angle[19:12], lateral_accel[35:20], zero pad
    input  logic [edts_pkg::IN_TW-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // right_torque[11:0], left_torque[23:12]
    output logic [edts_pkg::OUT_TW-1:0]   m_axis_tdata
);

    localparam int NSTAGE = 8;
    localparam int KW = edts_pkg::TORQUE_BITS;
    localparam logic [KW-1:0] TORQUE_MAX = {KW{1'b1}};
    localparam logic signed [edts_pkg::F1_W-1:0] ONE =
        edts_pkg::F1_W'(1) << edts_pkg::ONE_SHIFT;
    localparam logic signed [edts_pkg::F2_W-1:0] UNIT =
        edts_pkg::F2_W'(1) << edts_pkg::UNIT_SHIFT;

    // Configuration registers.
    logic [edts_pkg::MODE_W-1:0]  mode_reg;
    logic [edts_pkg::RATIO_W-1:0] track_ratio_reg;
    logic [edts_pkg::GAIN_W-1:0]  accel_gain_reg;
    logic [edts_pkg::DB_W-1:0]    dead_band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= edts_pkg::MODE_RESET;
            track_ratio_reg <= edts_pkg::RATIO_RESET;
            accel_gain_reg  <= edts_pkg::GAIN_RESET;
            dead_band_reg   <= edts_pkg::DEAD_BAND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                edts_pkg::REG_MODE:        mode_reg        <= cfg_data[edts_pkg::MODE_W-1:0];
                edts_pkg::REG_TRACK_RATIO: track_ratio_reg <= cfg_data[edts_pkg::RATIO_W-1:0];
                edts_pkg::REG_ACCEL_GAIN:  accel_gain_reg  <= cfg_data[edts_pkg::GAIN_W-1:0];
                edts_pkg::REG_DEAD_BAND:   dead_band_reg   <= cfg_data[edts_pkg::DB_W-1:0];
            endcase
        end
    end

    // Stage valid bits and load enables.
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] en;

    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_axis_tready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next = valid_reg;
        for (int i = 0; i < NSTAGE; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = (i == 0) ? s_axis_tvalid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[NSTAGE-1];

    // ------------------------------------------------------------------
    // Stage 1: angle magnitude, acceleration magnitude, wheel decisions.
    // ------------------------------------------------------------------
    logic [KW-1:0]                  in_k;
    logic [edts_pkg::ANG_W-1:0]     in_steer;
    logic [edts_pkg::ACC_W-1:0]     in_accel;
    logic [edts_pkg::ANG_W-1:0]     steer_abs;
    logic [edts_pkg::MAG_W-1:0]     mag;
    logic [edts_pkg::ACC_W-1:0]     accel_abs;
    logic                           s_pos;
    logic                           s_neg;
    logic [edts_pkg::ANG_W:0]       steer_x;
    logic [edts_pkg::ANG_W:0]       db_x;
    logic [edts_pkg::ANG_W:0]       db_sum;
    logic                           gt_db;
    logic                           lt_db;
    edts_pkg::lane_ctl_pair_t       ctl;

    assign in_k     = s_axis_tdata[KW-1:0];
    assign in_steer = s_axis_tdata[KW+edts_pkg::ANG_W-1:KW];
    assign in_accel = s_axis_tdata[edts_pkg::IN_W-1:KW+edts_pkg::ANG_W];

    always_comb
    begin
        steer_abs = in_steer[edts_pkg::ANG_W-1] ? -in_steer : in_steer;
        mag = (steer_abs > edts_pkg::ANG_W'(edts_pkg::ANGLE_MAX))
            ? edts_pkg::MAG_W'(edts_pkg::ANGLE_MAX) : steer_abs[edts_pkg::MAG_W-1:0];
        accel_abs = in_accel[edts_pkg::ACC_W-1] ? -in_accel : in_accel;
        s_neg = in_steer[edts_pkg::ANG_W-1];
        s_pos = !s_neg && (in_steer != '0);
        steer_x = {in_steer[edts_pkg::ANG_W-1], in_steer};
        db_x = (edts_pkg::ANG_W + 1)'(dead_band_reg);
        db_sum = steer_x + db_x;
        gt_db = $signed(steer_x) > $signed(db_x);
        lt_db = db_sum[edts_pkg::ANG_W];

        for (int l = 0; l < 2; l++)
        begin
            ctl[l].pass   = 1'b1;
            ctl[l].minus  = 1'b0;
            ctl[l].dbl    = 1'b0;
            ctl[l].use_ka = 1'b0;
        end
        // Lane 0 is the right wheel, lane 1 the left wheel.
        unique case (mode_reg)
            edts_pkg::MODE_PASS:
            begin
                ctl[0].pass = 1'b1;
                ctl[1].pass = 1'b1;
            end
            edts_pkg::MODE_INNER:
            begin
                ctl[0].pass  = !s_pos;
                ctl[1].pass  = !s_neg;
                ctl[0].minus = 1'b1;
                ctl[1].minus = 1'b1;
                ctl[0].dbl   = 1'b1;
                ctl[1].dbl   = 1'b1;
            end
            edts_pkg::MODE_HALF:
            begin
                ctl[0].pass  = !(s_pos || s_neg);
                ctl[1].pass  = !(s_pos || s_neg);
                ctl[0].minus = s_pos;
                ctl[1].minus = s_neg;
            end
            edts_pkg::MODE_DEAD:
            begin
                ctl[0].pass   = !(gt_db || lt_db);
                ctl[1].pass   = !(gt_db || lt_db);
                ctl[0].minus  = gt_db;
                ctl[1].minus  = lt_db;
                ctl[0].use_ka = 1'b1;
                ctl[1].use_ka = 1'b1;
            end
        endcase
    end

    logic [KW-1:0]                  k1_reg;
    logic [edts_pkg::MAG_W-1:0]     mag1_reg;
    logic [edts_pkg::ACC_W-1:0]     ax1_reg;
    edts_pkg::lane_ctl_pair_t       ctl1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            k1_reg   <= in_k;
            mag1_reg <= mag;
            ax1_reg  <= accel_abs;
            ctl1_reg <= ctl;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: tangent table lookup.
    // ------------------------------------------------------------------
    logic [KW-1:0]                  k2_reg;
    logic [edts_pkg::TAN_W-1:0]     tan2_reg;
    logic [edts_pkg::ACC_W-1:0]     ax2_reg;
    edts_pkg::lane_ctl_pair_t       ctl2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            k2_reg   <= k1_reg;
            tan2_reg <= edts_pkg::TAN_ROM[mag1_reg];
            ax2_reg  <= ax1_reg;
            ctl2_reg <= ctl1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: ratio term and acceleration term products.
    // ------------------------------------------------------------------
    logic [KW-1:0]                  k3_reg;
    logic [edts_pkg::P_W-1:0]       p3_reg;
    logic [edts_pkg::KA_W-1:0]      ka3_reg;
    edts_pkg::lane_ctl_pair_t       ctl3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            k3_reg   <= k2_reg;
            p3_reg   <= edts_pkg::P_W'(track_ratio_reg) * edts_pkg::P_W'(tan2_reg);
            ka3_reg  <= edts_pkg::KA_W'(accel_gain_reg) * edts_pkg::KA_W'(ax2_reg);
            ctl3_reg <= ctl2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: both factors per wheel, as magnitude and a zero flag.
    // ------------------------------------------------------------------
    logic [edts_pkg::P_W:0]             pm   [2];
    logic signed [edts_pkg::F1_W-1:0]   f1   [2];
    logic signed [edts_pkg::F1_W-1:0]   f1a  [2];
    logic [edts_pkg::KA_W-1:0]          kav  [2];
    logic signed [edts_pkg::F2_W-1:0]   f2   [2];
    logic signed [edts_pkg::F2_W-1:0]   f2a  [2];
    logic [1:0]                         zero;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            pm[l] = ctl3_reg[l].dbl ? {p3_reg, 1'b0} : {1'b0, p3_reg};
            f1[l] = ctl3_reg[l].minus ? ONE - $signed(edts_pkg::F1_W'(pm[l]))
                                      : ONE + $signed(edts_pkg::F1_W'(pm[l]));
            kav[l] = ctl3_reg[l].use_ka ? ka3_reg : '0;
            f2[l] = ctl3_reg[l].minus ? UNIT - $signed(edts_pkg::F2_W'(kav[l]))
                                      : UNIT + $signed(edts_pkg::F2_W'(kav[l]));
            f1a[l] = f1[l][edts_pkg::F1_W-1] ? -f1[l] : f1[l];
            f2a[l] = f2[l][edts_pkg::F2_W-1] ? -f2[l] : f2[l];
            // Factors of opposite sign give a negative torque, clamped to zero.
            zero[l] = (f1[l] == '0) || (f2[l] == '0)
                   || (f1[l][edts_pkg::F1_W-1] != f2[l][edts_pkg::F2_W-1]);
        end
    end

    logic [KW-1:0]                      k4_reg;
    logic [1:0][edts_pkg::F1M_W-1:0]    f1m4_reg;
    logic [1:0][edts_pkg::F2M_W-1:0]    f2m4_reg;
    logic [1:0]                         zero4_reg;
    logic [1:0]                         pass4_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            k4_reg <= k3_reg;
            for (int l = 0; l < 2; l++)
            begin
                f1m4_reg[l]  <= f1a[l][edts_pkg::F1M_W-1:0];
                f2m4_reg[l]  <= f2a[l][edts_pkg::F2M_W-1:0];
                zero4_reg[l] <= zero[l];
                pass4_reg[l] <= ctl3_reg[l].pass;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: torque times the first factor.
    // ------------------------------------------------------------------
    logic [KW-1:0]                      k5_reg;
    logic [1:0][edts_pkg::A_W-1:0]      a5_reg;
    logic [1:0][edts_pkg::F2M_W-1:0]    f2m5_reg;
    logic [1:0]                         zero5_reg;
    logic [1:0]                         pass5_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            k5_reg <= k4_reg;
            for (int l = 0; l < 2; l++)
            begin
                a5_reg[l] <= edts_pkg::A_W'(k4_reg) * edts_pkg::A_W'(f1m4_reg[l]);
            end
            f2m5_reg  <= f2m4_reg;
            zero5_reg <= zero4_reg;
            pass5_reg <= pass4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: low partial product of the second factor.
    // ------------------------------------------------------------------
    logic [KW-1:0]                      k6_reg;
    logic [1:0][edts_pkg::A_W-1:0]      a6_reg;
    logic [1:0][edts_pkg::LO_W-1:0]     lo6_reg;
    logic [1:0][edts_pkg::F2H_W-1:0]    f2h6_reg;
    logic [1:0]                         zero6_reg;
    logic [1:0]                         pass6_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            k6_reg <= k5_reg;
            for (int l = 0; l < 2; l++)
            begin
                lo6_reg[l] <= edts_pkg::LO_W'(a5_reg[l])
                            * edts_pkg::LO_W'(f2m5_reg[l][edts_pkg::F2L_W-1:0]);
                f2h6_reg[l] <= f2m5_reg[l][edts_pkg::F2M_W-1:edts_pkg::F2L_W];
            end
            a6_reg    <= a5_reg;
            zero6_reg <= zero5_reg;
            pass6_reg <= pass5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: high partial product of the second factor.
    // ------------------------------------------------------------------
    logic [KW-1:0]                      k7_reg;
    logic [1:0][edts_pkg::LO_W-1:0]     lo7_reg;
    logic [1:0][edts_pkg::HI_W-1:0]     hi7_reg;
    logic [1:0]                         zero7_reg;
    logic [1:0]                         pass7_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            k7_reg <= k6_reg;
            for (int l = 0; l < 2; l++)
            begin
                hi7_reg[l] <= edts_pkg::HI_W'(a6_reg[l]) * edts_pkg::HI_W'(f2h6_reg[l]);
            end
            lo7_reg   <= lo6_reg;
            zero7_reg <= zero6_reg;
            pass7_reg <= pass6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: partial product sum, scaling, saturation, output register.
    // ------------------------------------------------------------------
    logic [edts_pkg::PROD_W-1:0]    prod [2];
    logic [KW-1:0]                  res  [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            prod[l] = edts_pkg::PROD_W'(lo7_reg[l])
                    + (edts_pkg::PROD_W'(hi7_reg[l]) << edts_pkg::F2L_W);
            if (pass7_reg[l])
            begin
                res[l] = k7_reg;
            end
            else if (zero7_reg[l])
            begin
                res[l] = '0;
            end
            else if (|prod[l][edts_pkg::PROD_W-1:edts_pkg::OUT_SHIFT+KW])
            begin
                res[l] = TORQUE_MAX;
            end
            else
            begin
                res[l] = prod[l][edts_pkg::OUT_SHIFT+KW-1:edts_pkg::OUT_SHIFT];
            end
        end
    end

    logic [edts_pkg::OUT_TW-1:0] tdata_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            tdata_reg <= edts_pkg::OUT_TW'({res[1], res[0]});
        end
    end

    assign m_axis_tdata = tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // In the inner-wheel mode at most one wheel is derated.
    a_inner_one_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (en[0] && s_axis_tvalid && mode_reg == edts_pkg::MODE_INNER)
        |=> (ctl1_reg[0].pass || ctl1_reg[1].pass))
        else $error("inner-wheel mode derates both wheels");

    // In the symmetric and deadband modes exactly one wheel takes the minus branch unless both pass.
    a_one_minus: assert property (@(posedge clk) disable iff (!rst_n)
        (en[0] && s_axis_tvalid && !ctl[0].pass
         && (mode_reg == edts_pkg::MODE_HALF || mode_reg == edts_pkg::MODE_DEAD))
        |=> (ctl1_reg[0].minus != ctl1_reg[1].minus))
        else $error("split does not have exactly one minus wheel");

    // A wheel on the plus branch can never be clamped to zero.
    a_plus_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en[3] && valid_reg[2] && !ctl3_reg[0].pass && !ctl3_reg[0].minus)
        |=> !zero4_reg[0])
        else $error("plus branch flagged as zero");

    // A stage held by a stall keeps its item.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NSTAGE-2] && !en[NSTAGE-1]) |=> valid_reg[NSTAGE-2])
        else $error("stalled stage lost its item");

endmodule
